>>> rtl/closest_pair_two_point_sets_macros.svh
// Assertion macros used by the checker file.
`ifndef CLOSEST_PAIR_TWO_POINT_SETS_MACROS_SVH
`define CLOSEST_PAIR_TWO_POINT_SETS_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define CPTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define CPTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cpts_pkg.sv
package cpts_pkg;

    // Store geometry
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Coordinates and distances
    localparam int COORD_W    = 12;
    localparam int SQ_PART_W  = 2 * COORD_W;
    localparam int SQ_W       = SQ_PART_W + 1;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_W     = 21;

    // Square root unit: two radicand bits per step
    localparam int RAD_W      = 2 * DIST_W;
    localparam int RAD_PAD_W  = RAD_W - SQ_W - 2 * FRAC_BITS;
    localparam int REM_W      = DIST_W + 3;
    localparam int ITER_W     = $clog2(DIST_W + 1);

    // Input opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    localparam int POINT_W = $bits(point_t);

endpackage

>>> rtl/cpts_ram.sv
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/closest_pair_two_point_sets.sv
// Load transaction: the next transaction is accepted in the following cycle.
// Query transaction: one stored point is read per cycle from the point RAM,
// then the scan waits for the pipeline to drain.
// The last query then runs the 21-step square root before the result
// is registered; the next transaction is accepted while the result waits.
// Reset (rst_n low, asynchronous) empties the store and clears the best pair.
module closest_pair_two_point_sets
    import cpts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [SQ_W-1:0]    min_square,
    output logic [DIST_W-1:0]  distance_fixed,
    output logic [COORD_W-1:0] first_x,
    output logic [COORD_W-1:0] first_y,
    output logic [COORD_W-1:0] second_x,
    output logic [COORD_W-1:0] second_y,
    output logic               overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;

    // Control state
    logic [1:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  issue_reg,   issue_next;
    logic              rd_v_reg,    rd_v_next;
    logic              sq_v_reg,    sq_v_next;
    logic              dropped_reg, dropped_next;
    logic              any_reg,     any_next;
    logic [ITER_W-1:0] iter_reg,    iter_next;
    logic              out_v_reg,   out_v_next;

    // Payload state
    point_t            query_reg,   query_next;
    logic              qlast_reg,   qlast_next;
    logic [SQ_W-1:0]   best_sq_reg, best_sq_next;
    point_t            best_f_reg,  best_f_next;
    point_t            best_s_reg,  best_s_next;
    logic [SQ_PART_W-1:0] dxx_reg,  dxx_next;
    logic [SQ_PART_W-1:0] dyy_reg,  dyy_next;
    point_t            cand_reg,    cand_next;
    logic [RAD_W-1:0]  rad_reg,     rad_next;
    logic [REM_W-1:0]  rem_reg,     rem_next;
    logic [DIST_W-1:0] root_reg,    root_next;

    // Result register
    logic              o_found_reg, o_found_next;
    logic [SQ_W-1:0]   o_sq_reg,    o_sq_next;
    logic [DIST_W-1:0] o_dist_reg,  o_dist_next;
    point_t            o_f_reg,     o_f_next;
    point_t            o_s_reg,     o_s_next;
    logic              o_ovf_reg,   o_ovf_next;

    // RAM ports
    logic              wr_en;
    logic              rd_en;
    point_t            wr_point;
    point_t            rd_point;
    logic [POINT_W-1:0] rd_data;

    // Datapath intermediates
    logic [COORD_W-1:0]   adx, ady;
    logic [SQ_W-1:0]      dist_sum;
    logic [REM_W-1:0]     rem_sh, trial;
    logic                 trial_ge;
    logic                 in_acc;
    logic                 store_full;

    // Loads happen only in idle and reads only in scan, so the RAM
    // never sees a read and a write of the same entry in one cycle.
    cpts_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_point = point_t'(rd_data);

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign store_full = (count_reg == CNT_W'(MAX_POINTS));
    assign wr_point   = '{x: x, y: y};
    assign wr_en      = in_acc && (opcode == OP_LOAD) && !store_full;
    assign rd_en      = (state_reg == ST_SCAN) && (issue_reg != count_reg);

    // Stage A: absolute differences against the stored point
    assign adx = (query_reg.x >= rd_point.x) ? (query_reg.x - rd_point.x)
                                             : (rd_point.x - query_reg.x);
    assign ady = (query_reg.y >= rd_point.y) ? (query_reg.y - rd_point.y)
                                             : (rd_point.y - query_reg.y);

    // Stage B: squared distance
    assign dist_sum = {1'b0, dxx_reg} + {1'b0, dyy_reg};

    // Square root step: bring down two radicand bits, try subtracting 4r+1
    assign rem_sh   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign trial_ge = (rem_sh >= trial);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        rd_v_next    = rd_en;
        sq_v_next    = rd_v_reg;
        dropped_next = dropped_reg;
        any_next     = any_reg;
        iter_next    = iter_reg;
        out_v_next   = out_v_reg;
        query_next   = query_reg;
        qlast_next   = qlast_reg;
        best_sq_next = best_sq_reg;
        best_f_next  = best_f_reg;
        best_s_next  = best_s_reg;
        dxx_next     = SQ_PART_W'(adx) * SQ_PART_W'(adx);
        dyy_next     = SQ_PART_W'(ady) * SQ_PART_W'(ady);
        cand_next    = rd_point;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        o_found_next = o_found_reg;
        o_sq_next    = o_sq_reg;
        o_dist_next  = o_dist_reg;
        o_f_next     = o_f_reg;
        o_s_next     = o_s_reg;
        o_ovf_next   = o_ovf_reg;

        // Result handshake
        if (out_v_reg && out_ready)
        begin
            out_v_next = 1'b0;
        end

        // Best-pair update; ties go to the later pair
        if (sq_v_reg && (!any_reg || (dist_sum <= best_sq_reg)))
        begin
            best_sq_next = dist_sum;
            best_f_next  = query_reg;
            best_s_next  = cand_reg;
            any_next     = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        if (store_full)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        query_next = '{x: x, y: y};
                        qlast_next = last;
                        issue_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                // Done once all reads are issued and the pipe has drained
                if (!rd_en && !rd_v_reg && !sq_v_reg)
                begin
                    if (qlast_reg)
                    begin
                        rad_next   = {{RAD_PAD_W{1'b0}}, best_sq_reg, {2*FRAC_BITS{1'b0}}};
                        rem_next   = '0;
                        root_next  = '0;
                        iter_next  = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SQRT:
            begin
                if (iter_reg != ITER_W'(DIST_W))
                begin
                    rem_next  = trial_ge ? (rem_sh - trial) : rem_sh;
                    root_next = {root_reg[DIST_W-2:0], trial_ge};
                    rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                    iter_next = iter_reg + 1'b1;
                end
                else if (!out_v_reg || out_ready)
                begin
                    // Register the result and return to the reset state
                    out_v_next   = 1'b1;
                    o_found_next = any_reg;
                    o_sq_next    = best_sq_reg;
                    o_dist_next  = root_reg;
                    o_f_next     = best_f_reg;
                    o_s_next     = best_s_reg;
                    o_ovf_next   = dropped_reg;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    any_next     = 1'b0;
                    best_sq_next = '0;
                    best_f_next  = '0;
                    best_s_next  = '0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            rd_v_reg    <= 1'b0;
            sq_v_reg    <= 1'b0;
            dropped_reg <= 1'b0;
            any_reg     <= 1'b0;
            iter_reg    <= '0;
            out_v_reg   <= 1'b0;
            best_sq_reg <= '0;
            best_f_reg  <= '0;
            best_s_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            rd_v_reg    <= rd_v_next;
            sq_v_reg    <= sq_v_next;
            dropped_reg <= dropped_next;
            any_reg     <= any_next;
            iter_reg    <= iter_next;
            out_v_reg   <= out_v_next;
            best_sq_reg <= best_sq_next;
            best_f_reg  <= best_f_next;
            best_s_reg  <= best_s_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        query_reg   <= query_next;
        qlast_reg   <= qlast_next;
        dxx_reg     <= dxx_next;
        dyy_reg     <= dyy_next;
        cand_reg    <= cand_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        o_found_reg <= o_found_next;
        o_sq_reg    <= o_sq_next;
        o_dist_reg  <= o_dist_next;
        o_f_reg     <= o_f_next;
        o_s_reg     <= o_s_next;
        o_ovf_reg   <= o_ovf_next;
    end

    assign out_valid      = out_v_reg;
    assign found          = o_found_reg;
    assign min_square     = o_sq_reg;
    assign distance_fixed = o_dist_reg;
    assign first_x        = o_f_reg.x;
    assign first_y        = o_f_reg.y;
    assign second_x       = o_s_reg.x;
    assign second_y       = o_s_reg.y;
    assign overflow       = o_ovf_reg;

endmodule

>>> rtl/cpts_checker.sv
`include "closest_pair_two_point_sets_macros.svh"

module cpts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        opcode,
    input logic [11:0] x,
    input logic [11:0] y,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [24:0] min_square,
    input logic [20:0] distance_fixed,
    input logic [11:0] first_x,
    input logic [11:0] first_y,
    input logic [11:0] second_x,
    input logic [11:0] second_y,
    input logic        overflow
);

    // A stalled result keeps its value
    `CPTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(min_square) && $stable(distance_fixed), "result changed while stalled")

    // Nothing compared means all result fields are zero
    `CPTS_ASSERT(a_empty_zero, out_valid && !found |-> min_square == 25'd0 && distance_fixed == 21'd0 && first_x == 12'd0 && first_y == 12'd0 && second_x == 12'd0 && second_y == 12'd0, "empty result not zero")

    // Distance is a lower bound of the scaled square root
    `CPTS_ASSERT(a_sqrt_floor, out_valid |-> ({21'd0, distance_fixed} * {21'd0, distance_fixed}) <= {1'b0, min_square, 16'd0}, "distance above square root")

    // A query always occupies at least the next cycle
    `CPTS_ASSERT(a_query_busy, in_valid && in_ready && opcode |=> !in_ready, "query did not block input")

endmodule

bind closest_pair_two_point_sets cpts_checker u_cpts_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpts_pkg::*;

    // One pending input transaction
    typedef struct {
        logic               op;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               lst;
        bit                 drain;
    } point_txn_t;

    // One predicted closest-pair result
    typedef struct packed {
        logic              found;
        logic [SQ_W-1:0]   sq;
        logic [DIST_W-1:0] dist_fx;
        point_t            first;
        point_t            second;
        logic              ovf;
    } closest_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_LOAD;
    logic [COORD_W-1:0] x = '0;
    logic [COORD_W-1:0] y = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               found;
    logic [SQ_W-1:0]    min_square;
    logic [DIST_W-1:0]  distance_fixed;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic               overflow;

    // Stimulus and expectations
    point_txn_t pending_pts[$];
    closest_t   closest_q[$];

    // Predictor state
    point_t        stored_pts [MAX_POINTS];
    int            stored_n;
    logic [SQ_W:0] best_sq;
    point_t        best_first;
    point_t        best_second;
    logic          have_pair;
    logic          lost_load;

    // Bookkeeping
    int total_items;
    int calm_mark;
    int items_sent = 0;
    int results_seen = 0;
    int pending_results = 0;
    int mismatches = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit long_hold_done = 0;
    int no_pair_results = 0;
    int overflow_results = 0;
    int dropped_loads = 0;
    logic calm;

    assign calm = (items_sent >= calm_mark);

    closest_pair_two_point_sets u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .x              (x),
        .y              (y),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .min_square     (min_square),
        .distance_fixed (distance_fixed),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .overflow       (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor(sqrt(sq) * 256), bit by bit from the top
    function automatic logic [DIST_W-1:0] fixed_root(input longint unsigned sq);
        longint unsigned rad;
        longint unsigned cand;
        logic [DIST_W-1:0] root;
        rad = sq << (2 * FRAC_BITS);
        root = '0;
        for (int b = DIST_W - 1; b >= 0; b--)
        begin
            cand = {{(64 - DIST_W){1'b0}}, root} | (64'd1 << b);
            if (cand * cand <= rad)
                root[b] = 1'b1;
        end
        return root;
    endfunction

    // Search state back to its power-up values
    task automatic clear_search();
        stored_n    = 0;
        best_sq     = '1;
        best_first  = '0;
        best_second = '0;
        have_pair   = 1'b0;
        lost_load   = 1'b0;
    endtask

    // Advance the predictor by one accepted transaction
    task automatic absorb_point(input logic op, input logic [COORD_W-1:0] px,
                                input logic [COORD_W-1:0] py, input logic lst);
        longint dx;
        longint dy;
        longint unsigned d;
        closest_t res;
        if (op == OP_LOAD)
        begin
            if (stored_n < MAX_POINTS)
            begin
                stored_pts[stored_n].x = px;
                stored_pts[stored_n].y = py;
                stored_n++;
            end
            else
            begin
                lost_load = 1'b1;
                dropped_loads++;
            end
        end
        else
        begin
            for (int i = 0; i < stored_n; i++)
            begin
                dx = longint'(px) - longint'(stored_pts[i].x);
                dy = longint'(py) - longint'(stored_pts[i].y);
                d = dx * dx + dy * dy;
                // ties go to the later pair
                if (d <= best_sq)
                begin
                    best_sq       = (SQ_W + 1)'(d);
                    best_first.x  = px;
                    best_first.y  = py;
                    best_second   = stored_pts[i];
                    have_pair     = 1'b1;
                end
            end
            if (lst)
            begin
                res = '0;
                if (have_pair)
                begin
                    res.found   = 1'b1;
                    res.sq      = best_sq[SQ_W-1:0];
                    res.dist_fx = fixed_root(best_sq);
                    res.first   = best_first;
                    res.second  = best_second;
                end
                else
                    no_pair_results++;
                res.ovf = lost_load;
                if (lost_load)
                    overflow_results++;
                closest_q.push_back(res);
                clear_search();
            end
        end
    endtask

    task automatic check_field(input string tag, input longint unsigned want,
                               input longint unsigned seen);
        if (want != seen)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", tag, want, seen);
        end
    endtask

    task automatic queue_item(input logic op, input int px, input int py,
                              input logic lst, input bit drain);
        point_txn_t t;
        t.op    = op;
        t.px    = COORD_W'(px);
        t.py    = COORD_W'(py);
        t.lst   = lst;
        t.drain = drain;
        pending_pts.push_back(t);
    endtask

    // Coordinate near c, or anywhere for a wide spread
    function automatic int near(input int c, input int spread);
        int v;
        if (spread >= 4095)
            return $urandom_range(0, 4095);
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // Driver: presents queued transactions, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        point_txn_t nxt;
        logic owed;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            owed = in_valid && !in_ready;
            if (!owed)
            begin
                if (in_valid && !calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 3);
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pts.size() > 0 &&
                         !(pending_pts[0].drain && (pending_results != 0 || in_valid)))
                begin
                    nxt = pending_pts.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= nxt.op;
                    x        <= nxt.px;
                    y        <= nxt.py;
                    last     <= nxt.lst;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 12)
        begin
            long_hold_done = 1;
            stall_left = 400;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: check results first, then feed accepted inputs to the predictor
    always @(posedge clk)
    begin
        closest_t want;
        int got;
        int took;
        if (rst_n)
        begin
            got = 0;
            took = 0;
            if (out_valid && out_ready)
            begin
                got = 1;
                if (closest_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found %0d min_square %0d",
                                 found, min_square);
                end
                else
                begin
                    want = closest_q.pop_front();
                    check_field("found", want.found, found);
                    check_field("min_square", want.sq, min_square);
                    check_field("distance_fixed", want.dist_fx, distance_fixed);
                    check_field("first_x", want.first.x, first_x);
                    check_field("first_y", want.first.y, first_y);
                    check_field("second_x", want.second.x, second_x);
                    check_field("second_y", want.second.y, second_y);
                    check_field("overflow", want.ovf, overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                took = 1;
                absorb_point(opcode, x, y, last);
            end
            items_sent      <= items_sent + took;
            results_seen    <= results_seen + got;
            pending_results <= closest_q.size();
        end
    end

    initial
    begin
        int n_load;
        int n_query;
        int cx;
        int cy;
        int spread;
        int random_start;
        bit mixed;
        bit drain;
        bit first_set;
        logic op;

        clear_search();

        // Directed: query on an empty store
        queue_item(OP_QUERY, 7, 9, 1'b1, 0);
        // Corners, last on a load, zero distance, tie across queries
        queue_item(OP_LOAD, 0, 0, 1'b1, 0);
        queue_item(OP_LOAD, 4095, 4095, 1'b0, 0);
        queue_item(OP_QUERY, 0, 0, 1'b0, 0);
        queue_item(OP_QUERY, 4095, 4095, 1'b1, 0);
        // Largest possible distance
        queue_item(OP_LOAD, 0, 0, 1'b0, 0);
        queue_item(OP_QUERY, 4095, 4095, 1'b1, 0);
        // Tie inside one query: the later stored point wins
        queue_item(OP_LOAD, 10, 10, 1'b0, 0);
        queue_item(OP_LOAD, 12, 10, 1'b0, 0);
        queue_item(OP_QUERY, 11, 10, 1'b1, 0);
        // Alternating bit patterns
        queue_item(OP_LOAD, 12'hAAA, 12'h555, 1'b1, 0);
        queue_item(OP_QUERY, 12'h555, 12'hAAA, 1'b1, 0);
        // Query before any load, then loads, then the closing query
        queue_item(OP_QUERY, 5, 5, 1'b0, 0);
        queue_item(OP_LOAD, 100, 200, 1'b0, 0);
        queue_item(OP_LOAD, 4000, 17, 1'b1, 0);
        queue_item(OP_QUERY, 300, 400, 1'b1, 0);

        // Full store plus dropped loads
        for (int i = 0; i < MAX_POINTS + 2; i++)
            queue_item(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       1'($urandom_range(0, 1)), 0);
        queue_item(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 0);
        queue_item(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 0);
        queue_item(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1, 0);

        // Random contour pairs
        random_start = pending_pts.size();
        first_set = 1;
        while (pending_pts.size() < random_start + 580)
        begin
            n_load  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60)
                                                  : $urandom_range(0, 10);
            n_query = $urandom_range(1, 5);
            mixed   = ($urandom_range(0, 3) == 0);
            cx      = $urandom_range(0, 4095);
            cy      = $urandom_range(0, 4095);
            spread  = $urandom_range(0, 1) ? 4095 : $urandom_range(1, 20);
            drain   = first_set || ($urandom_range(0, 11) == 0);
            first_set = 0;
            while (n_load + n_query > 0)
            begin
                if (n_load == 0)
                    op = OP_QUERY;
                else if (n_query <= 1)
                    op = OP_LOAD;
                else if (mixed)
                    op = $urandom_range(0, 1) ? OP_QUERY : OP_LOAD;
                else
                    op = OP_LOAD;
                if (op == OP_LOAD)
                begin
                    queue_item(OP_LOAD, near(cx, spread), near(cy, spread),
                               1'($urandom_range(0, 1)), drain);
                    n_load--;
                end
                else
                begin
                    queue_item(OP_QUERY, near(cx, spread), near(cy, spread),
                               (n_query == 1), drain);
                    n_query--;
                end
                drain = 0;
            end
        end

        total_items = pending_pts.size();
        calm_mark   = total_items - 60;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_sent == total_items && pending_results == 0);
        repeat (40) @(posedge clk);

        $display("sent %0d transactions, checked %0d closest-pair results", items_sent,
                 results_seen);
        $display("%0d results with no pair, %0d with overflow, %0d loads dropped",
                 no_pair_results, overflow_results, dropped_loads);
        if (mismatches == 0 && closest_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", closest_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/cpts_pkg.sv
rtl/cpts_ram.sv
rtl/closest_pair_two_point_sets.sv
rtl/cpts_checker.sv
tb/testbench.sv
